// ===== hdl/trfp_pkg.sv =====
// Package for the text record frame parser: command, event, error and
// parser state codes, character constants and the tag lookup.
// No dependencies.
package trfp_pkg;

  // Default sizes of the name, value and hex message limits
  localparam int unsigned NAME_LEN_DEF  = 9;
  localparam int unsigned VALUE_LEN_DEF = 33;
  localparam int unsigned HEX_LEN_DEF   = 100;

  // Checksum record tag and error counter limit
  localparam int unsigned TAG_LEN     = 8;
  localparam int unsigned NUM_ERR     = 5;
  localparam logic [15:0] COUNT_LIMIT = 16'd50000;

  // Characters
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_CASE  = 8'd32;
  localparam logic [7:0] CH_TOP   = 8'd128;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_GAP   = 2'd1,
    CMD_AGING = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    EV_NONE    = 4'd0,
    EV_NAME    = 4'd1,
    EV_VALUE   = 4'd2,
    EV_KEPT    = 4'd3,
    EV_DROPPED = 4'd4,
    EV_GOOD    = 4'd5,
    EV_BAD     = 4'd6,
    EV_HEXCHAR = 4'd7,
    EV_HEXEND  = 4'd8
  } ev_e;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_GAP    = 3'd1,
    ERR_CHAR   = 3'd2,
    ERR_NEST   = 3'd3,
    ERR_SUM    = 3'd4,
    ERR_HEXOVF = 3'd5
  } err_code_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_BEGIN = 3'd1,
    ST_NAME  = 3'd2,
    ST_VALUE = 3'd3,
    ST_CHECK = 3'd4,
    ST_HEX   = 3'd5
  } parse_state_e;

  // Request from the parser to the error counters
  typedef struct packed {
    logic      en;    // item accepted, error raised and start-up passed
    err_code_e code;
  } err_req_t;

  // Characters of the checksum record name
  function automatic logic [7:0] tag_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h43;  // C
      3'd1:    ch = 8'h48;  // H
      3'd2:    ch = 8'h45;  // E
      3'd3:    ch = 8'h43;  // C
      3'd4:    ch = 8'h4B;  // K
      3'd5:    ch = 8'h53;  // S
      3'd6:    ch = 8'h55;  // U
      default: ch = 8'h4D;  // M
    endcase
    return ch;
  endfunction

endpackage

// ===== hdl/trfp_in_if.sv =====
// Input channel of the text record frame parser: valid/ready plus one item.
// No dependencies.
interface trfp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

// ===== hdl/trfp_out_if.sv =====
// Output channel of the text record frame parser: valid/ready plus one item.
// No dependencies.
interface trfp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [7:0]  data_byte;
  logic [2:0]  error_code;
  logic [15:0] error_count;
  logic        data_valid;
  logic        startup_done;

  modport source (output valid, output event_res, output data_byte, output error_code,
                  output error_count, output data_valid, output startup_done,
                  input ready);
  modport sink   (input valid, input event_res, input data_byte, input error_code,
                  input error_count, input data_valid, input startup_done,
                  output ready);
endinterface

// ===== hdl/trfp_err_counter.sv =====
// Error counters of the text record frame parser, one per error kind,
// all halved once one passes the limit. Depends on trfp_pkg.
module trfp_err_counter import trfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  err_req_t    req_i,
  output logic [15:0] count_o
);

  logic [15:0] cnt_q [NUM_ERR];
  logic [15:0] cnt_d [NUM_ERR];
  logic [15:0] inc   [NUM_ERR];
  logic        over;

  // Increment the selected kind, then halve all if any passes the limit
  always_comb begin
    over = 1'b0;
    for (int i = 0; i < NUM_ERR; i++) begin
      inc[i] = cnt_q[i] + {15'd0, (req_i.code == err_code_e'(3'(i + 1)))};
      if (inc[i] > COUNT_LIMIT) over = 1'b1;
    end
    for (int i = 0; i < NUM_ERR; i++) begin
      if (!req_i.en) begin
        cnt_d[i] = cnt_q[i];
      end else if (over) begin
        cnt_d[i] = {1'b0, inc[i][15:1]};
      end else begin
        cnt_d[i] = inc[i];
      end
    end
  end

  // Count of the requested kind after the update
  always_comb begin
    case (req_i.code)
      ERR_GAP:    count_o = cnt_d[0];
      ERR_CHAR:   count_o = cnt_d[1];
      ERR_NEST:   count_o = cnt_d[2];
      ERR_SUM:    count_o = cnt_d[3];
      ERR_HEXOVF: count_o = cnt_d[4];
      default:    count_o = 16'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ERR; i++) cnt_q[i] <= 16'd0;
    end else begin
      for (int i = 0; i < NUM_ERR; i++) cnt_q[i] <= cnt_d[i];
    end
  end

endmodule

// ===== hdl/text_record_frame_parser_core.sv =====
// Top level of the text record frame parser: byte parser, checksum and
// result register. Depends on trfp_pkg, trfp_in_if, trfp_out_if, trfp_err_counter.
//
//   port    dir  handshake     item
//   in_i    in   valid/ready   command, rx_byte
//   out_o   out  valid/ready   event_res, data_byte, error_code, error_count,
//                              data_valid, startup_done
//
// One item per cycle while out_o is not stalled: each accepted item updates
// the parser state and loads the result register at the same edge; the result
// appears the next cycle. in_i.ready stays high while the result register is
// empty or being taken, so a stalled out_o holds one result and stops the input.
// Reset (rst_ni low, asynchronous) returns the parser to idle and clears
// the flags and error counters; no clearing pass is needed.
module text_record_frame_parser_core import trfp_pkg::*; #(
  parameter int unsigned NAME_LEN  = NAME_LEN_DEF,
  parameter int unsigned VALUE_LEN = VALUE_LEN_DEF,
  parameter int unsigned HEX_LEN   = HEX_LEN_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  trfp_in_if.sink    in_i,
  trfp_out_if.source out_o
);

  localparam int unsigned NL_W = $clog2(NAME_LEN + 1);
  localparam int unsigned VL_W = $clog2(VALUE_LEN + 1);
  localparam int unsigned HL_W = $clog2(HEX_LEN + 1);

  // Parser state
  parse_state_e   state_q, state_d, st_cur, saved_q, saved_d;
  logic [7:0]     sum_q, sum_d;
  logic [NL_W-1:0] name_len_q, name_len_d;
  logic           name_tag_q, name_tag_d;
  logic           name_v_q, name_v_d;
  logic [VL_W-1:0] val_len_q, val_len_d;
  logic           has_v_q, has_v_d;
  logic [HL_W-1:0] hex_len_q, hex_len_d, hl_cur, hl_inc;
  logic           startup_q, startup_d;
  logic           valid_q, valid_d;

  // Result register
  logic           out_valid_q;
  logic [3:0]     ev_q;
  logic [7:0]     data_q;
  logic [2:0]     err_q;
  logic [15:0]    cnt_q;
  logic           dv_q, sd_q;

  logic           accept;
  logic [7:0]     b, c;
  logic           char_ok;
  ev_e            ev;
  logic [7:0]     data;
  err_code_e      err;
  err_req_t       err_req;
  logic [15:0]    err_cnt;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign b       = in_i.rx_byte;
  assign c       = (b >= CH_LO_A && b <= CH_LO_Z) ? (b - CH_CASE) : b;
  assign char_ok = (b == CH_TAB) || (b == CH_LF) || (b == CH_CR) ||
                   (b >= CH_SPACE && b < CH_TOP);

  // Per-item state update and result
  always_comb begin
    state_d    = state_q;
    saved_d    = saved_q;
    sum_d      = sum_q;
    name_len_d = name_len_q;
    name_tag_d = name_tag_q;
    name_v_d   = name_v_q;
    val_len_d  = val_len_q;
    has_v_d    = has_v_q;
    hex_len_d  = hex_len_q;
    startup_d  = startup_q;
    valid_d    = valid_q;
    ev         = EV_NONE;
    data       = 8'd0;
    err        = ERR_NONE;
    st_cur     = state_q;
    hl_cur     = hex_len_q;
    hl_inc     = hex_len_q + 1'b1;

    case (cmd_e'(in_i.command))
      CMD_AGING: begin
        if (valid_q) begin
          valid_d   = 1'b0;
          startup_d = 1'b0;
        end
      end
      CMD_GAP: begin
        if (state_q != ST_IDLE) begin
          err     = ERR_GAP;
          ev      = EV_BAD;
          sum_d   = 8'd0;
          state_d = ST_IDLE;
          has_v_d = 1'b0;
        end
      end
      CMD_BYTE: begin
        if (state_q != ST_CHECK && !char_ok) begin
          err     = ERR_CHAR;
          ev      = EV_BAD;
          sum_d   = 8'd0;
          state_d = ST_IDLE;
          has_v_d = 1'b0;
        end else begin
          // colon opens a hex message, restarting one already open
          if (b == CH_COLON && state_q != ST_CHECK) begin
            if (state_q == ST_HEX) begin
              err = ERR_NEST;
            end else begin
              saved_d = state_q;
            end
            st_cur = ST_HEX;
            hl_cur = '0;
          end
          hl_inc  = hl_cur + 1'b1;
          state_d = st_cur;
          if (st_cur != ST_HEX) sum_d = sum_q + b;

          case (st_cur)
            ST_IDLE: begin
              if (c == CH_LF) state_d = ST_BEGIN;
            end
            ST_BEGIN: begin
              name_len_d = NL_W'(1);
              name_tag_d = (c == tag_char(3'd0));
              name_v_d   = (c == CH_V);
              state_d    = ST_NAME;
              ev         = EV_NAME;
              data       = c;
            end
            ST_NAME: begin
              if (c == CH_TAB) begin
                if (name_len_q < NL_W'(NAME_LEN) && name_len_q == NL_W'(TAG_LEN) &&
                    name_tag_q) begin
                  state_d = ST_CHECK;
                  ev      = EV_DROPPED;
                end else begin
                  val_len_d = '0;
                  state_d   = ST_VALUE;
                end
              end else if (c != CH_HASH && name_len_q < NL_W'(NAME_LEN)) begin
                if (!(name_len_q < NL_W'(TAG_LEN) && tag_char(name_len_q[2:0]) == c)) begin
                  name_tag_d = 1'b0;
                end
                name_len_d = name_len_q + 1'b1;
                ev         = EV_NAME;
                data       = c;
              end
            end
            ST_VALUE: begin
              if (c == CH_LF) begin
                if (val_len_q < VL_W'(VALUE_LEN)) begin
                  ev = EV_KEPT;
                  if (name_len_q == NL_W'(1) && name_v_q) has_v_d = 1'b1;
                end else begin
                  ev = EV_DROPPED;
                end
                state_d = ST_BEGIN;
              end else if (c != CH_CR && val_len_q < VL_W'(VALUE_LEN)) begin
                val_len_d = val_len_q + 1'b1;
                ev        = EV_VALUE;
                data      = c;
              end
            end
            ST_CHECK: begin
              // check byte: running sum including it must be zero
              if (sum_d == 8'd0) begin
                if (has_v_q) begin
                  if (startup_q) valid_d = 1'b1;
                  startup_d = 1'b1;
                end
                ev = EV_GOOD;
              end else begin
                err = ERR_SUM;
                ev  = EV_BAD;
              end
              sum_d   = 8'd0;
              state_d = ST_IDLE;
              has_v_d = 1'b0;
            end
            default: begin
              // hex message: newline resumes the interrupted text state
              if (c == CH_LF) begin
                ev        = EV_HEXEND;
                hex_len_d = hl_cur;
                state_d   = (saved_d <= ST_VALUE) ? saved_d : ST_IDLE;
              end else if (hl_inc >= HL_W'(HEX_LEN)) begin
                err       = ERR_HEXOVF;
                hex_len_d = '0;
                state_d   = ST_IDLE;
                ev        = EV_HEXEND;
              end else begin
                hex_len_d = hl_inc;
                ev        = EV_HEXCHAR;
                data      = c;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  assign err_req.en   = accept && startup_q && (err != ERR_NONE);
  assign err_req.code = err;

  trfp_err_counter u_err_counter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (err_req),
    .count_o (err_cnt)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      saved_q     <= ST_IDLE;
      sum_q       <= 8'd0;
      name_len_q  <= '0;
      name_tag_q  <= 1'b1;
      name_v_q    <= 1'b0;
      val_len_q   <= '0;
      has_v_q     <= 1'b0;
      hex_len_q   <= '0;
      startup_q   <= 1'b0;
      valid_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q    <= state_d;
        saved_q    <= saved_d;
        sum_q      <= sum_d;
        name_len_q <= name_len_d;
        name_tag_q <= name_tag_d;
        name_v_q   <= name_v_d;
        val_len_q  <= val_len_d;
        has_v_q    <= has_v_d;
        hex_len_q  <= hex_len_d;
        startup_q  <= startup_d;
        valid_q    <= valid_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_q   <= ev;
      data_q <= data;
      err_q  <= err;
      cnt_q  <= (err != ERR_NONE) ? err_cnt : 16'd0;
      dv_q   <= valid_d;
      sd_q   <= startup_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.event_res    = ev_q;
  assign out_o.data_byte    = data_q;
  assign out_o.error_code   = err_q;
  assign out_o.error_count  = cnt_q;
  assign out_o.data_valid   = dv_q;
  assign out_o.startup_done = sd_q;

endmodule
